### hdl/ito_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ito_pkg
// Shared types and constants for the incremental topological order block.
// ----------------------------------------------------------------------------
package ito_pkg;
    localparam int NODES = 64;
    localparam int NW    = $clog2(NODES);
    localparam int CW    = NW + 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_ORDER  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_CYCLE = 2'd2;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK_RD, S_CHECK, S_ROW_RD, S_SCAN, S_TEST,
        S_POP, S_POP2, S_RESULT, S_ORD_RD, S_ORD_CMP, S_ORD_OUT
    } state_t;

    typedef struct packed {
        logic          clear;
        logic          load;
        logic          chk_rd;
        logic          set_edge;
        logic          raise_v;
        logic          row_rd;
        logic          scan;
        logic          test;
        logic          pop;
        logic          restore;
        logic          lab_cur_ld;
        logic          ord_init;
        logic          ord_rd;
        logic          ord_adv;
        logic          ord_cnt;
    } ctl_cmd_t;

    typedef struct packed {
        logic          clr_done;
        logic          in_range;
        logic          is_query;
        logic          qans;
        logic          need_raise;
        logic          self_loop;
        logic          scan_none;
        logic          last_frame;
        logic          hit;
        logic          hit_origin;
        logic          hit_change;
        logic          stk_full;
        logic          ord_match;
        logic          ord_total;
    } ctl_sts_t;
endpackage
`default_nettype wire

### hdl/ito_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ito_in_if / ito_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface ito_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [5:0] from_node;
    logic [5:0] to_node;
    modport source (output valid, cmd, from_node, to_node, input ready);
    modport sink   (input valid, cmd, from_node, to_node, output ready);
endinterface

interface ito_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       answer;
    logic [5:0] node_out;
    logic       last;
    modport source (output valid, status, answer, node_out, last, input ready);
    modport sink   (input valid, status, answer, node_out, last, output ready);
endinterface
`default_nettype wire

### hdl/ito_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ito_datapath
// Labels, successor matrix, walk stack and order scan registers.
// ----------------------------------------------------------------------------
module ito_datapath
    import ito_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  cmd,
    input  wire logic [5:0]  from_node,
    input  wire logic [5:0]  to_node,
    input  wire logic [CW-1:0] count,
    input  wire ctl_cmd_t    cc,
    output ctl_sts_t         st,
    output logic [5:0]       ord_node
);
    logic [NW-1:0]    lab_mem  [NODES];
    logic [NODES-1:0] succ_mem [NODES];
    logic [NW+CW-1:0] stk_mem  [NODES];

    logic [NW-1:0]    lab_a_reg, lab_b_reg;
    logic [NODES-1:0] row_reg;
    logic [NW+CW-1:0] stk_reg;

    logic [NW-1:0] u_reg, v_reg, cur_reg, x_reg, idx_reg, lab_scan_reg, lab_cur_reg;
    logic [1:0]    cmd_reg;
    logic [CW-1:0] pos_reg, depth_reg, k_reg;

    logic [NW-1:0]    nl_cur, nl_u, stk_node, found;
    logic [CW-1:0]    stk_pos, push_ix, pop_ix;
    logic [NODES-1:0] low_mask, cand;
    logic [NW:0]      first;
    logic             ord_idx_end;
    logic             push;
    logic             lab_we;
    logic [NW-1:0]    lab_wa, lab_wd;
    logic             succ_we;
    logic [NW-1:0]    succ_wa;
    logic [NODES-1:0] succ_wd;
    logic [NW-1:0]    lab_ra_a, lab_ra_b, succ_ra;

    function automatic logic [NW-1:0] raise(input logic [NW-1:0] l);
        if (l == NW'(NODES - 1)) return NW'(NODES - 1);
        return l + NW'(1);
    endfunction

    function automatic logic [NW:0] first_set(input logic [NODES-1:0] b);
        logic [NW:0] r;
        r = {1'b1, {NW{1'b0}}};
        for (int i = NODES - 1; i >= 0; i--)
            if (b[i]) r = {1'b0, NW'(i)};
        return r;
    endfunction

    assign stk_node = stk_reg[NW+CW-1:CW];
    assign stk_pos  = stk_reg[CW-1:0];
    assign nl_cur   = raise(lab_cur_reg);
    assign nl_u     = raise(lab_a_reg);
    assign low_mask = (NODES'(1) << pos_reg) - NODES'(1);
    assign cand     = row_reg & ~low_mask;
    assign first    = first_set(cand);
    assign found    = first[NW-1:0];
    assign push_ix  = depth_reg - CW'(1);
    assign pop_ix   = depth_reg - CW'(2);
    assign ord_idx_end = (CW'(idx_reg) + CW'(1) >= count);
    assign ord_node = idx_reg;

    always_comb
    begin
        st.clr_done   = (idx_reg == NW'(NODES - 1));
        st.in_range   = (CW'(u_reg) < count) && (CW'(v_reg) < count);
        st.is_query   = (cmd_reg == CMD_QUERY);
        st.qans       = lab_a_reg < lab_b_reg;
        st.need_raise = lab_a_reg >= lab_b_reg;
        st.self_loop  = (u_reg == v_reg);
        st.scan_none  = first[NW];
        st.last_frame = (depth_reg == CW'(1));
        st.hit        = (lab_cur_reg >= lab_b_reg);
        st.hit_origin = (x_reg == u_reg);
        st.hit_change = (nl_cur != lab_b_reg);
        st.stk_full   = (depth_reg == CW'(NODES));
        st.ord_match  = (lab_b_reg == lab_scan_reg);
        st.ord_total  = (k_reg + CW'(1) >= count);
    end

    assign push = cc.test && st.hit && !st.hit_origin && st.hit_change && !st.stk_full;

    always_comb
    begin
        lab_we  = 1'b0;
        lab_wa  = idx_reg;
        lab_wd  = '0;
        succ_we = 1'b0;
        succ_wa = idx_reg;
        succ_wd = '0;
        if (cc.clear)
        begin
            lab_we  = 1'b1;
            succ_we = 1'b1;
        end
        else
        begin
            if (cc.raise_v)
            begin
                lab_we = 1'b1;
                lab_wa = v_reg;
                lab_wd = nl_u;
            end
            else if (cc.test && st.hit)
            begin
                lab_we = 1'b1;
                lab_wa = x_reg;
                lab_wd = nl_cur;
            end
            if (cc.set_edge)
            begin
                succ_we = 1'b1;
                succ_wa = u_reg;
                succ_wd = row_reg | (NODES'(1) << v_reg);
            end
        end
        lab_ra_a = cc.restore ? stk_node : u_reg;
        lab_ra_b = cc.scan ? found : (cc.ord_rd ? idx_reg : v_reg);
        succ_ra  = cc.restore ? stk_node : (cc.row_rd ? cur_reg : u_reg);
    end

    always_ff @(posedge clk)
    begin
        if (lab_we) lab_mem[lab_wa] <= lab_wd;
        if (cc.chk_rd || cc.restore) lab_a_reg <= lab_mem[lab_ra_a];
        if (cc.chk_rd || cc.scan || cc.ord_rd) lab_b_reg <= lab_mem[lab_ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (succ_we) succ_mem[succ_wa] <= succ_wd;
        if (cc.chk_rd || cc.row_rd || cc.restore) row_reg <= succ_mem[succ_ra];
    end

    always_ff @(posedge clk)
    begin
        if (push) stk_mem[push_ix[NW-1:0]] <= {cur_reg, pos_reg};
        if (cc.pop) stk_reg <= stk_mem[pop_ix[NW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cc.clear)
            idx_reg <= idx_reg + NW'(1);
        else if (cc.ord_init)
            idx_reg <= '0;
        else if (cc.ord_adv)
            idx_reg <= ord_idx_end ? '0 : idx_reg + NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cc.load)
        begin
            u_reg   <= from_node[NW-1:0];
            v_reg   <= to_node[NW-1:0];
            cmd_reg <= cmd;
        end
        if (cc.raise_v)
        begin
            cur_reg     <= v_reg;
            pos_reg     <= '0;
            lab_cur_reg <= nl_u;
            depth_reg   <= CW'(1);
        end
        if (cc.scan)
        begin
            x_reg   <= found;
            pos_reg <= CW'(found) + CW'(1);
        end
        if (push)
        begin
            cur_reg     <= x_reg;
            pos_reg     <= '0;
            lab_cur_reg <= nl_cur;
            depth_reg   <= depth_reg + CW'(1);
        end
        if (cc.pop) depth_reg <= depth_reg - CW'(1);
        if (cc.restore)
        begin
            cur_reg <= stk_node;
            pos_reg <= stk_pos;
        end
        if (cc.lab_cur_ld) lab_cur_reg <= lab_a_reg;
        if (cc.ord_init)
        begin
            lab_scan_reg <= '0;
            k_reg        <= '0;
        end
        if (cc.ord_adv && ord_idx_end) lab_scan_reg <= lab_scan_reg + NW'(1);
        if (cc.ord_cnt) k_reg <= k_reg + CW'(1);
    end
endmodule
`default_nettype wire

### hdl/ito_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ito_ctrl
// Command sequencer: range check, edge insert, label walk, order scan.
// ----------------------------------------------------------------------------
module ito_ctrl
    import ito_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_cmd,
    output logic            in_ready,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [1:0]      out_status,
    output logic            out_answer,
    output logic            out_sel_node,
    output logic            out_last,
    input  wire ctl_sts_t   st,
    output ctl_cmd_t        cc
);
    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       ans_reg, ans_next;
    logic       last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            status_reg <= ST_OK;
            ans_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            ans_reg    <= ans_next;
            last_reg   <= last_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        ans_next     = ans_reg;
        last_next    = last_reg;
        cc           = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        out_sel_node = 1'b0;
        out_status   = status_reg;
        out_answer   = ans_reg;
        out_last     = last_reg;
        case (state_reg)
            S_INIT:
            begin
                cc.clear = 1'b1;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cc.load = 1'b1;
                    case (in_cmd)
                        CMD_INSERT, CMD_QUERY: state_next = S_CHECK_RD;
                        CMD_ORDER:
                        begin
                            cc.ord_init = 1'b1;
                            state_next  = S_ORD_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CHECK_RD:
            begin
                cc.chk_rd  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                status_next = ST_OK;
                ans_next    = 1'b0;
                last_next   = 1'b1;
                state_next  = S_RESULT;
                if (!st.in_range)
                    status_next = ST_RANGE;
                else if (st.is_query)
                    ans_next = st.qans;
                else
                begin
                    cc.set_edge = 1'b1;
                    if (st.need_raise)
                    begin
                        cc.raise_v = 1'b1;
                        if (st.self_loop)
                            status_next = ST_CYCLE;
                        else
                            state_next = S_ROW_RD;
                    end
                end
            end
            S_ROW_RD:
            begin
                cc.row_rd  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (st.scan_none)
                begin
                    if (st.last_frame)
                        state_next = S_RESULT;
                    else
                    begin
                        cc.pop     = 1'b1;
                        state_next = S_POP;
                    end
                end
                else
                begin
                    cc.scan    = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                cc.test    = 1'b1;
                state_next = S_SCAN;
                if (st.hit && (st.hit_origin || (st.hit_change && st.stk_full)))
                begin
                    status_next = ST_CYCLE;
                    state_next  = S_RESULT;
                end
                else if (st.hit && st.hit_change)
                    state_next = S_ROW_RD;
            end
            S_POP:
            begin
                cc.restore = 1'b1;
                state_next = S_POP2;
            end
            S_POP2:
            begin
                cc.lab_cur_ld = 1'b1;
                state_next    = S_SCAN;
            end
            S_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            S_ORD_RD:
            begin
                cc.ord_rd  = 1'b1;
                state_next = S_ORD_CMP;
            end
            S_ORD_CMP:
            begin
                if (st.ord_match)
                begin
                    state_next = S_ORD_OUT;
                    last_next  = st.ord_total;
                end
                else
                begin
                    cc.ord_adv = 1'b1;
                    state_next = S_ORD_RD;
                end
            end
            S_ORD_OUT:
            begin
                out_valid    = 1'b1;
                out_sel_node = 1'b1;
                out_status   = ST_OK;
                out_answer   = 1'b0;
                if (out_ready)
                begin
                    if (last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        cc.ord_adv = 1'b1;
                        cc.ord_cnt = 1'b1;
                        state_next = S_ORD_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hdl/incremental_topological_order.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_topological_order
// Incremental topological labeling with cycle detection and order listing.
// ----------------------------------------------------------------------------
// Channel    Dir  Words
// in_ch      in   cmd, from_node, to_node
// out_ch     out  status, answer, node_out, last
// cfg        in   node_count (write enable + data)
// Query, rejected insert, insert without raise: S_CHECK_RD, then S_CHECK, then S_RESULT.
// Insert walk: S_SCAN and S_TEST per stored successor examined; S_ROW_RD, a final S_SCAN,
// S_POP and S_POP2 per node entered and left. Order: S_ORD_RD then S_ORD_CMP per (label, node)
// probe, up to node_count probes per label. Only out_ch.ready stalls; the next word is accepted
// the cycle after the last result. Reset: a pass over all NODES entries clears labels and edges,
// in_ch.ready low; node_count = NODES.
module incremental_topological_order
    import ito_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ito_in_if.sink          in_ch,
    ito_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);
    logic [CW-1:0] count_reg;
    ctl_cmd_t      cc;
    ctl_sts_t      st;
    logic [5:0]    ord_node;
    logic          sel_node;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CW'(NODES);
        else if (cfg_we)
        begin
            if (cfg_wdata == 7'd0)
                count_reg <= CW'(1);
            else if (cfg_wdata > 7'(NODES))
                count_reg <= CW'(NODES);
            else
                count_reg <= CW'(cfg_wdata);
        end
    end

    ito_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_cmd       (in_ch.cmd),
        .in_ready     (in_ch.ready),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_status   (out_ch.status),
        .out_answer   (out_ch.answer),
        .out_sel_node (sel_node),
        .out_last     (out_ch.last),
        .st           (st),
        .cc           (cc)
    );

    ito_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (in_ch.cmd),
        .from_node (in_ch.from_node),
        .to_node   (in_ch.to_node),
        .count     (count_reg),
        .cc        (cc),
        .st        (st),
        .ord_node  (ord_node)
    );

    assign out_ch.node_out = sel_node ? ord_node : 6'd0;
endmodule
`default_nettype wire

### test/tb_incremental_topological_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_incremental_topological_order
// Drives insert, query and order commands in bursts through the valid/ready
// channels, predicts labels, edges and listings, and checks every result word.
// ----------------------------------------------------------------------------
module tb_incremental_topological_order;
    import ito_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       answer;
        logic [5:0] node_out;
        logic       last;
    } result_word_t;

    class order_scoreboard;
        int unsigned  used_nodes;
        logic [5:0]   label[NODES];
        logic [63:0]  succ[NODES];
        result_word_t pending[$];
        int           mismatches;

        function new();
            used_nodes = NODES;
            mismatches = 0;
            foreach (label[i])
            begin
                label[i] = '0;
                succ[i] = '0;
            end
        endfunction

        function void set_count(logic [6:0] value);
            used_nodes = (value < 1) ? 1 : ((value > NODES) ? NODES : value);
        endfunction

        function logic [5:0] bump(logic [5:0] lab);
            return (lab + 1 >= NODES - 1) ? 6'(NODES - 1) : 6'(lab + 1);
        endfunction

        function bit raise_from(int start, int origin);
            int stk_node[NODES];
            int stk_pos[NODES];
            int sp;
            int cur;
            int x;
            logic [5:0] nl;
            logic [5:0] prev;
            stk_node[0] = start;
            stk_pos[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                cur = stk_node[sp - 1];
                if (stk_pos[sp - 1] >= NODES)
                begin
                    sp--;
                    continue;
                end
                x = stk_pos[sp - 1];
                stk_pos[sp - 1]++;
                if (succ[cur][x] && label[cur] >= label[x])
                begin
                    nl = bump(label[cur]);
                    prev = label[x];
                    label[x] = nl;
                    if (x == origin)
                        return 1;
                    if (nl != prev)
                    begin
                        if (sp >= NODES)
                            return 1;
                        stk_node[sp] = x;
                        stk_pos[sp] = 0;
                        sp++;
                    end
                end
            end
            return 0;
        endfunction

        function void note_command(logic [1:0] cmd, logic [5:0] u, logic [5:0] v);
            result_word_t w;
            int total;
            int k;
            w = '0;
            if (cmd == CMD_INSERT || cmd == CMD_QUERY)
            begin
                w.last = 1'b1;
                if (u >= used_nodes || v >= used_nodes)
                    w.status = ST_RANGE;
                else if (cmd == CMD_QUERY)
                    w.answer = label[u] < label[v];
                else
                begin
                    succ[u][v] = 1'b1;
                    if (label[u] >= label[v])
                    begin
                        label[v] = bump(label[u]);
                        if (u == v || raise_from(v, u))
                            w.status = ST_CYCLE;
                    end
                end
                pending.insert(pending.size(), w);
            end
            else if (cmd == CMD_ORDER)
            begin
                total = used_nodes;
                k = 0;
                for (int lab = 0; lab < NODES && k < total; lab++)
                    for (int i = 0; i < used_nodes && k < total; i++)
                        if (label[i] == lab)
                        begin
                            w = '0;
                            w.node_out = 6'(i);
                            w.last = (k + 1 == total);
                            pending.insert(pending.size(), w);
                            k++;
                        end
            end
        endfunction

        function void check_word(result_word_t got);
            result_word_t exp_w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word %p", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected %p got %p", exp_w, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;
    longint cycles;
    int unsigned gap_left;
    order_scoreboard sb;

    ito_in_if in_ch();
    ito_out_if out_ch();

    incremental_topological_order i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 20000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_word({out_ch.status, out_ch.answer, out_ch.node_out, out_ch.last});

    // stall pattern: quiet stretches alternate with random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if ((cycles / 500) % 3 == 0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 99) < 65);
    end

    task automatic send_word(logic [1:0] cmd, logic [5:0] u, logic [5:0] v);
        int unsigned idle;
        if (gap_left == 0)
        begin
            idle = $urandom_range(0, 6);
            if (idle != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (idle)
                    @(negedge clk);
            end
            gap_left = $urandom_range(1, 12);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.from_node <= u;
        in_ch.to_node <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_command(cmd, u, v);
        gap_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300)
            @(negedge clk);
    endtask

    task automatic write_count(logic [6:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_count(value);
    endtask

    task automatic random_phase(int n, int span);
        int r;
        logic [5:0] a;
        logic [5:0] b;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            a = 6'($urandom_range(0, span - 1));
            b = 6'($urandom_range(0, span - 1));
            if (r < 4)
                a = 6'($urandom);
            if (r < 55)
            begin
                if (a > b && $urandom_range(0, 3) != 0)
                    send_word(CMD_INSERT, b, a);
                else
                    send_word(CMD_INSERT, a, b);
            end
            else if (r < 82)
                send_word(CMD_QUERY, a, b);
            else if (r < 92)
                send_word(CMD_ORDER, a, b);
            else
                send_word(2'd3, a, b);
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        gap_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_INSERT;
        in_ch.from_node = '0;
        in_ch.to_node = '0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(CMD_ORDER, 6'd0, 6'd0);
        send_word(CMD_INSERT, 6'd0, 6'd63);
        send_word(CMD_INSERT, 6'd0, 6'd63);
        send_word(CMD_QUERY, 6'd0, 6'd63);
        send_word(CMD_QUERY, 6'd63, 6'd0);
        send_word(CMD_INSERT, 6'd5, 6'd5);
        send_word(CMD_INSERT, 6'd1, 6'd2);
        send_word(CMD_INSERT, 6'd2, 6'd3);
        send_word(CMD_INSERT, 6'd3, 6'd1);
        send_word(2'd3, 6'd63, 6'd63);
        send_word(CMD_ORDER, 6'd63, 6'd63);
        for (int i = 10; i < 62; i++)
            send_word(CMD_INSERT, 6'(i), 6'(i + 1));
        send_word(CMD_INSERT, 6'd62, 6'd63);
        send_word(CMD_INSERT, 6'd63, 6'd10);
        send_word(CMD_ORDER, 6'd0, 6'd0);

        write_count(7'd1);
        send_word(CMD_INSERT, 6'd0, 6'd1);
        send_word(CMD_QUERY, 6'd0, 6'd0);
        send_word(CMD_ORDER, 6'd0, 6'd0);
        write_count(7'd0);
        send_word(CMD_ORDER, 6'd0, 6'd0);
        write_count(7'd127);
        send_word(CMD_QUERY, 6'd63, 6'd62);

        write_count(7'd12);
        random_phase(47, 14);
        write_count(7'd64);
        random_phase(47, 64);
        write_count(7'd33);
        random_phase(47, 36);

        drain();
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### sim.f
hdl/ito_pkg.sv
hdl/ito_if.sv
hdl/ito_datapath.sv
hdl/ito_ctrl.sv
hdl/incremental_topological_order.sv
test/tb_incremental_topological_order.sv
